/* design/wsrx_pkg.sv */
package wsrx_pkg;

  typedef enum logic [2:0] {
    EvText   = 3'd0,
    EvEmpty  = 3'd1,
    EvOpened = 3'd2,
    EvFailed = 3'd3,
    EvClose  = 3'd4,
    EvPong   = 3'd5
  } event_kind_e;

  // Handshake scanner status for the byte being processed.
  typedef struct packed {
    logic done;  // byte completes CR LF CR LF
    logic ok;    // status prefix matched in full
  } hs_status_t;

  localparam logic [3:0] PrefixLen = 4'd12;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  // "HTTP/1.1 101"
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2F;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h31;
      4'd8:    c = 8'h20;
      4'd9:    c = 8'h31;
      4'd10:   c = 8'h30;
      4'd11:   c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/wsrx_hs.sv */
module wsrx_hs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output wsrx_pkg::hs_status_t  status_o
);

  logic [3:0] pos_q, pos_d;
  logic       mism_q, mism_d;
  logic [1:0] blank_q, blank_d;
  logic [7:0] expect_char;

  assign expect_char = blank_q[0] ? wsrx_pkg::CharLf : wsrx_pkg::CharCr;

  always_comb begin
    pos_d         = pos_q;
    mism_d        = mism_q;
    blank_d       = blank_q;
    status_o.done = 1'b0;
    if (pos_q < wsrx_pkg::PrefixLen) begin
      if (byte_i != wsrx_pkg::prefix_char(pos_q)) mism_d = 1'b1;
      pos_d = pos_q + 4'd1;
    end
    if (byte_i == expect_char) begin
      if (blank_q == 2'd3) begin
        status_o.done = 1'b1;
        blank_d       = 2'd0;
      end else begin
        blank_d = blank_q + 2'd1;
      end
    end else begin
      blank_d = (byte_i == wsrx_pkg::CharCr) ? 2'd1 : 2'd0;
    end
    status_o.ok = (pos_d == wsrx_pkg::PrefixLen) && !mism_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      mism_q  <= 1'b0;
      blank_q <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      mism_q  <= mism_d;
      blank_q <= blank_d;
    end
  end

endmodule

/* design/websocket_rx_deframer.sv */
// Receive deframer for a WebSocket client link. Bytes enter one per cycle on the
// in_* channel while the output register is free; each accepted byte sits in an
// input register, is parsed against the handshake and frame header state, and its
// event (if any) is loaded into the output register, so the block sustains one byte
// per clock unless the output stalls. That rate rests on the header phase, 64-bit
// remaining-length counter and mask key being updated together for each byte. After
// reset the block checks the HTTP status line for "HTTP/1.1 101" and
// waits for the blank line, then reports opened or failed. Text payload bytes come out
// unmasked with message_last on the final byte; empty text frames, pings (pong request)
// and close frames each give one event at frame end. After a close or a failed
// handshake every byte is dropped.
module websocket_rx_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       message_last_o
);

  typedef enum logic [1:0] {
    ModeHs     = 2'd0,
    ModeOpen   = 2'd1,
    ModeClosed = 2'd2
  } link_mode_e;

  localparam logic [3:0] PhFirst    = 4'd0;
  localparam logic [3:0] PhLen      = 4'd1;
  localparam logic [3:0] PhExt0     = 4'd2;
  localparam logic [3:0] PhExt1     = 4'd3;
  localparam logic [3:0] PhExtLast  = 4'd9;
  localparam logic [3:0] PhMask0    = 4'd10;
  localparam logic [3:0] PhMaskLast = 4'd13;
  localparam logic [3:0] PhPayload  = 4'd14;

  localparam logic [1:0] Form7  = 2'd0;
  localparam logic [1:0] Form16 = 2'd1;
  localparam logic [1:0] Form64 = 2'd2;

  // input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_free, proc;

  // parser state
  link_mode_e mode_q, mode_d;
  logic [3:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [1:0]  form_q, form_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] mask_q, mask_d;
  logic [1:0]  pos_q, pos_d;

  // output stage
  logic              out_valid_q;
  wsrx_pkg::event_kind_e kind_q;
  logic [7:0]        obyte_q;
  logic              olast_q;

  logic                  ev_valid;
  wsrx_pkg::event_kind_e ev_kind;
  logic [7:0]            ev_byte;
  logic                  ev_last;

  wsrx_pkg::hs_status_t hs_status;
  logic                 len_done, body_go, frame_end, frame_empty;
  logic [7:0]           key;
  logic                 pay_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || proc;

  wsrx_hs u_hs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (proc && (mode_q == ModeHs)),
    .byte_i   (in_byte_q),
    .status_o (hs_status)
  );

  always_comb begin
    case (pos_q)
      2'd0:    key = mask_q[31:24];
      2'd1:    key = mask_q[23:16];
      2'd2:    key = mask_q[15:8];
      default: key = mask_q[7:0];
    endcase
    if (!masked_q) key = 8'h00;
  end

  assign pay_last = (remain_q == 64'd1);

  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    masked_d    = masked_q;
    form_d      = form_q;
    remain_d    = remain_q;
    mask_d      = mask_q;
    pos_d       = pos_q;
    ev_valid    = 1'b0;
    ev_kind     = wsrx_pkg::EvText;
    ev_byte     = 8'h00;
    ev_last     = 1'b0;
    len_done    = 1'b0;
    body_go     = 1'b0;
    frame_end   = 1'b0;
    frame_empty = 1'b0;

    case (mode_q)
      ModeHs: begin
        if (hs_status.done) begin
          ev_valid = 1'b1;
          if (hs_status.ok) begin
            mode_d  = ModeOpen;
            phase_d = PhFirst;
            ev_kind = wsrx_pkg::EvOpened;
          end else begin
            mode_d  = ModeClosed;
            ev_kind = wsrx_pkg::EvFailed;
          end
        end
      end
      ModeOpen: begin
        case (phase_q)
          PhLen: begin
            masked_d = in_byte_q[7];
            mask_d   = '0;
            remain_d = '0;
            if (in_byte_q[6:0] == wsrx_pkg::Len16Code) begin
              form_d  = Form16;
              phase_d = PhExt0;
            end else if (in_byte_q[6:0] == wsrx_pkg::Len64Code) begin
              form_d  = Form64;
              phase_d = PhExt0;
            end else begin
              form_d   = Form7;
              remain_d = {57'd0, in_byte_q[6:0]};
              len_done = 1'b1;
            end
          end
          PhPayload: begin
            remain_d = remain_q - 64'd1;
            pos_d    = pos_q + 2'd1;
            if (opcode_q == wsrx_pkg::OpText) begin
              ev_valid = 1'b1;
              ev_kind  = wsrx_pkg::EvText;
              ev_byte  = in_byte_q ^ key;
              ev_last  = pay_last;
              if (pay_last) phase_d = PhFirst;
            end else if (pay_last) begin
              frame_end = 1'b1;
            end
          end
          default: begin
            if (phase_q >= PhExt0 && phase_q <= PhExtLast) begin
              remain_d = {remain_q[55:0], in_byte_q};
              if ((form_q == Form16 && phase_q >= PhExt1) || phase_q == PhExtLast) begin
                len_done = 1'b1;
              end else begin
                phase_d = phase_q + 4'd1;
              end
            end else if (phase_q >= PhMask0 && phase_q <= PhMaskLast) begin
              mask_d = {mask_q[23:0], in_byte_q};
              if (phase_q == PhMaskLast) body_go = 1'b1;
              else phase_d = phase_q + 4'd1;
            end else begin
              // first header byte, also taken for the unused phase code
              opcode_d = in_byte_q[3:0];
              phase_d  = PhLen;
            end
          end
        endcase
      end
      default: ;
    endcase

    if (len_done) begin
      if (masked_d) phase_d = PhMask0;
      else body_go = 1'b1;
    end
    if (body_go) begin
      if (remain_d == 64'd0) begin
        frame_end   = 1'b1;
        frame_empty = 1'b1;
      end else begin
        pos_d   = 2'd0;
        phase_d = PhPayload;
      end
    end
    if (frame_end) begin
      phase_d = PhFirst;
      if (opcode_q == wsrx_pkg::OpText) begin
        if (frame_empty) begin
          ev_valid = 1'b1;
          ev_kind  = wsrx_pkg::EvEmpty;
        end
      end else if (opcode_q == wsrx_pkg::OpClose) begin
        mode_d   = ModeClosed;
        ev_valid = 1'b1;
        ev_kind  = wsrx_pkg::EvClose;
      end else if (opcode_q == wsrx_pkg::OpPing) begin
        ev_valid = 1'b1;
        ev_kind  = wsrx_pkg::EvPong;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeHs;
      phase_q     <= PhFirst;
      opcode_q    <= '0;
      masked_q    <= 1'b0;
      form_q      <= Form7;
      remain_q    <= '0;
      mask_q      <= '0;
      pos_q       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) in_valid_q <= 1'b1;
      else if (proc) in_valid_q <= 1'b0;
      if (proc) out_valid_q <= ev_valid;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (proc) begin
        mode_q      <= mode_d;
        phase_q     <= phase_d;
        opcode_q    <= opcode_d;
        masked_q    <= masked_d;
        form_q      <= form_d;
        remain_q    <= remain_d;
        mask_q      <= mask_d;
        pos_q       <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_byte_q <= rx_byte_i;
    if (proc && ev_valid) begin
      kind_q  <= ev_kind;
      obyte_q <= ev_byte;
      olast_q <= ev_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign payload_byte_o = obyte_q;
  assign message_last_o = olast_q;

  a_last_only_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_last_o |-> event_kind_o == wsrx_pkg::EvText)
    else $error("message_last set on a non-text event");

  a_closed_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeClosed |=> mode_q == ModeClosed)
    else $error("link left the closed mode");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeOpen && phase_q == PhPayload |-> remain_q != 64'd0)
    else $error("payload phase with no bytes remaining");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_byte_q))
    else $error("input stage lost a byte while the output was stalled");

endmodule
